/* rtl/running_ecdf_distance_top_assert.svh */
// Assertion macros for the running ECDF distance top module.
`ifndef RUNNING_ECDF_DISTANCE_TOP_ASSERT_SVH
`define RUNNING_ECDF_DISTANCE_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define RED_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RED_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/red_pkg.sv */
// Package with types and constants for the running ECDF distance block.
package red_pkg;
  localparam int GridPoints = 256;
  localparam int Chains     = 4;
  localparam int MaxDim     = 4;
  localparam int CountBits  = 24;
  localparam int IdxW       = $clog2(GridPoints);
  localparam int MemDepth   = GridPoints * Chains;
  localparam int MemW       = $clog2(MemDepth);
  localparam int Stages     = 20;  // compare, count, 17 division bits, square
  localparam logic [CountBits-1:0] CountMax = '1;
  localparam logic [16:0] OneQ16 = 17'h10000;

  typedef enum logic [1:0] {
    CMD_LOAD_GRID   = 2'd0,
    CMD_LOAD_TARGET = 2'd1,
    CMD_SAMPLE      = 2'd2,
    CMD_CLEAR       = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    REG_DIMS = 1'd0,
    REG_GRID = 1'd1
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_WALK, ST_DRAIN, ST_DIVIDE, ST_OUT
  } state_e;

  // Token handed from cell to cell: one grid point at work.
  typedef struct packed {
    logic                 vld;
    logic [IdxW-1:0]      idx;
    logic [63:0]          grid;
    logic [16:0]          target;
    logic                 hit;
    logic [CountBits-1:0] count;
    logic [23+17:0]       num;     // count * 65536 + total / 2
    logic [16:0]          quo;     // ECDF value in Q1.16
    logic [34:0]          sq;      // squared gap in Q3.32
  } tok_t;
endpackage

/* rtl/red_div_cell.sv */
// One restoring-division cell: retires one quotient bit of the ECDF value.
module red_div_cell import red_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CountBits-1:0] total_i,
  input  logic [4:0]           bit_i,
  input  tok_t                 tok_i,
  output tok_t                 tok_o
);
  tok_t tok_d, tok_q;
  logic [64:0] shifted;

  always_comb begin
    tok_d = tok_i;
    shifted = {41'd0, total_i} << bit_i;
    if ({24'd0, tok_i.num} >= shifted) begin
      tok_d.num = tok_i.num - shifted[40:0];
      tok_d.quo = tok_i.quo | (17'd1 << bit_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end
  assign tok_o = tok_q;
endmodule

/* rtl/red_mean_div.sv */
// Sequential divider that forms the rounded mean of the summed squares.
module red_mean_div import red_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [51:0] sum_i,
  input  logic [8:0]  g_i,
  output logic        done_o,
  output logic [31:0] mean_o
);
  logic [60:0] rem_d, rem_q;
  logic [51:0] quo_d, quo_q;
  logic [5:0]  cnt_d, cnt_q;
  logic        busy_d, busy_q, done_d, done_q;
  logic [60:0] trial;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[59:0], quo_q[51]};
    if (start_i) begin
      rem_d = '0; quo_d = sum_i + {44'd0, g_i[8:1]}; cnt_d = 6'd52; busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[50:0], 1'b0};
      if (trial >= {52'd0, g_i}) begin
        rem_d = trial - {52'd0, g_i}; quo_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d;
  end
  assign done_o = done_q;
  assign mean_o = (quo_q[51:32] != '0) ? 32'hFFFF_FFFF : quo_q[31:0];
endmodule

/* rtl/running_ecdf_distance_top.sv */
// Flow: a sample walks the grid points in use and drains through the cell row, then goes
// through mean division and an output state held until m_axis_tready; loads are written
// straight into their table. Words are taken only in idle, so each sample finishes before
// the next is taken; a clear sweeps 1024 entries, one per cycle.
// Reset: rst_ni asynchronously zeroes totals and pipeline registers, sets dims to 1 and the
// grid to 256 and starts the clear sweep of the counts, during which no word is accepted.
`include "running_ecdf_distance_top_assert.svh"
module running_ecdf_distance_top import red_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: cmd[1:0], chain[3:2], grid_index[11:4], coord_a..coord_d[75:12],
  // target_value[92:76], zero fill to 96 bits
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: result_chain[1:0], distance[33:2], zero fill to 40 bits
  output logic [39:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [8:0]   cfg_data_i
);
  logic [2:0]  dims_q;
  logic [8:0]  gridr_q;
  logic [2:0]  dims_eff;
  logic [8:0]  g_eff;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= 3'd1; gridr_q <= 9'd256;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_DIMS: dims_q  <= cfg_data_i[2:0];
        REG_GRID: gridr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end
  assign dims_eff = (dims_q == 3'd0) ? 3'd1 : ((dims_q > 3'd4) ? 3'd4 : dims_q);
  assign g_eff = (gridr_q == 9'd0) ? 9'd1 : ((gridr_q > 9'd256) ? 9'd256 : gridr_q);

  logic [1:0]  in_cmd, in_chain;
  logic [7:0]  in_idx;
  logic [63:0] in_coord;
  logic [16:0] in_tgt;
  assign in_cmd = s_axis_tdata[1:0];
  assign in_chain = s_axis_tdata[3:2];
  assign in_idx = s_axis_tdata[11:4];
  assign in_coord = s_axis_tdata[75:12];
  assign in_tgt = s_axis_tdata[92:76];

  state_e st_q, st_d;
  logic [MemW:0] cnt_q, cnt_d;
  logic [1:0]  ch_q;
  logic [63:0] x_q;
  logic [CountBits-1:0] total_q;
  logic [CountBits-1:0] seen_q [Chains];
  logic [51:0] sum_q;
  logic [31:0] dist_q;
  logic        acc;
  logic        div_start, div_done;
  logic [31:0] div_mean;

  assign acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (st_q == ST_IDLE);

  // Memories.
  logic [63:0] grid_mem [GridPoints];
  logic [16:0] tgt_mem  [GridPoints];
  logic [CountBits-1:0] cnt_mem [MemDepth];
  logic [63:0] grid_rd;
  logic [16:0] tgt_rd;
  logic [CountBits-1:0] cnt_rd;
  logic        rd_vld_q;
  logic [IdxW-1:0] rd_idx_q;

  always_ff @(posedge clk_i) begin
    if (acc && cmd_e'(in_cmd) == CMD_LOAD_GRID) grid_mem[in_idx] <= in_coord;
    if (acc && cmd_e'(in_cmd) == CMD_LOAD_TARGET)
      tgt_mem[in_idx] <= (in_tgt > OneQ16) ? OneQ16 : in_tgt;
    grid_rd <= grid_mem[cnt_q[IdxW-1:0]];
    tgt_rd <= tgt_mem[cnt_q[IdxW-1:0]];
    cnt_rd <= cnt_mem[{ch_q, cnt_q[IdxW-1:0]}];
    rd_idx_q <= cnt_q[IdxW-1:0];
  end

  // Cell row: stage 0 compares, stage 1 counts, then division cells, then square.
  tok_t t0_d, t0_q, t1_d, t1_q;
  tok_t row [Stages-1];
  logic hit;
  always_comb begin
    hit = 1'b1;
    for (int k = 0; k < MaxDim; k++)
      if (k < int'(dims_eff) && $signed(x_q[16*k+:16]) > $signed(grid_rd[16*k+:16]))
        hit = 1'b0;
  end

  logic wr_en;
  logic [MemW-1:0] wr_addr;
  logic [CountBits-1:0] wr_val;
  logic [CountBits-1:0] newc;
  assign newc = (t0_q.hit && t0_q.count != CountMax) ? t0_q.count + 1'b1 : t0_q.count;

  always_comb begin
    t0_d = '0;
    t0_d.vld = rd_vld_q; t0_d.idx = rd_idx_q; t0_d.grid = grid_rd; t0_d.target = tgt_rd;
    t0_d.hit = hit; t0_d.count = cnt_rd;
    t1_d = t0_q;
    t1_d.count = newc;
    t1_d.num = {1'b0, newc, 16'd0} + {18'd0, total_q[23:1]};
    t1_d.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0; t0_q <= '0; t1_q <= '0;
    end else begin
      rd_vld_q <= (st_q == ST_WALK) && (cnt_q < {1'b0, 1'b0, g_eff});
      t0_q <= t0_d;
      t1_q <= t1_d;
    end
  end
  assign wr_en = t0_q.vld;
  assign wr_addr = {ch_q, t0_q.idx};
  assign wr_val = newc;

  assign row[0] = t1_q;
  for (genvar s = 0; s < Stages - 2; s++) begin : g_cell
    if (s < 17) begin : g_div
      red_div_cell u_cell (
        .clk_i, .rst_ni, .total_i(total_q), .bit_i(5'(16 - s)),
        .tok_i(row[s]), .tok_o(row[s+1])
      );
    end else begin : g_sq
      logic [16:0] q;
      logic signed [17:0] d;
      logic [16:0] gap_s;
      logic [33:0] sq_w;
      tok_t sq_d, sq_q;
      assign q = row[s].quo;
      assign d = $signed({1'b0, q}) - $signed({1'b0, row[s].target});
      assign gap_s = d[17] ? 17'(-d) : d[16:0];
      assign sq_w = {17'd0, gap_s} * {17'd0, gap_s};
      always_comb begin
        sq_d = '0;
        sq_d.vld = row[s].vld;
        sq_d.idx = row[s].idx;
        sq_d.sq = {1'b0, sq_w};
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) sq_q <= '0;
        else sq_q <= sq_d;
      end
      assign row[s+1] = sq_q;
    end
  end

  // Count memory write: clear sweep or update from the row.
  always_ff @(posedge clk_i) begin
    if (st_q == ST_CLEAR) cnt_mem[cnt_q[MemW-1:0]] <= '0;
    else if (wr_en) cnt_mem[wr_addr] <= wr_val;
  end

  always_comb begin
    st_d = st_q; cnt_d = cnt_q;
    case (st_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (acc && cmd_e'(in_cmd) == CMD_CLEAR) st_d = ST_CLEAR;
        else if (acc && cmd_e'(in_cmd) == CMD_SAMPLE) st_d = ST_WALK;
      end
      ST_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (MemW+1)'(MemDepth - 1)) st_d = ST_IDLE;
      end
      ST_WALK: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == {2'b0, g_eff}) begin
          st_d = ST_DRAIN; cnt_d = '0;
        end
      end
      ST_DRAIN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (MemW+1)'(Stages + 2)) st_d = ST_DIVIDE;
      end
      ST_DIVIDE: if (div_done) st_d = ST_OUT;
      ST_OUT: if (m_axis_tready) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end
  assign div_start = (st_q == ST_DRAIN) && (st_d == ST_DIVIDE);

  logic [CountBits-1:0] inc_seen;
  assign inc_seen = (seen_q[in_chain] == CountMax) ? CountMax : seen_q[in_chain] + 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR; cnt_q <= '0; sum_q <= '0; total_q <= '0; ch_q <= '0; x_q <= '0;
      dist_q <= '0;
      for (int c = 0; c < Chains; c++) seen_q[c] <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d;
      if (acc && cmd_e'(in_cmd) == CMD_CLEAR)
        for (int c = 0; c < Chains; c++) seen_q[c] <= '0;
      if (acc && cmd_e'(in_cmd) == CMD_SAMPLE) begin
        seen_q[in_chain] <= inc_seen; total_q <= inc_seen;
        ch_q <= in_chain; x_q <= in_coord; sum_q <= '0;
      end else if (row[Stages-2].vld) begin
        sum_q <= sum_q + {17'd0, row[Stages-2].sq};
      end
      if (div_done) dist_q <= div_mean;
    end
  end

  red_mean_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .sum_i(sum_q), .g_i(g_eff),
    .done_o(div_done), .mean_o(div_mean)
  );

  assign m_axis_tvalid = (st_q == ST_OUT);
  assign m_axis_tdata = {6'd0, dist_q, ch_q};

  `RED_ASSERT_IMP(a_ready_idle, s_axis_tready, !m_axis_tvalid)
  `RED_ASSERT_NXT(a_sample_walk, acc && cmd_e'(in_cmd) == CMD_SAMPLE, st_q == ST_WALK)
  `RED_ASSERT_NXT(a_done_out, div_done, m_axis_tvalid)
  `RED_ASSERT_IMP(a_total_nz, st_q == ST_WALK, total_q != '0)
endmodule

/* tb/sv/running_ecdf_distance_top_test.sv */
// Self-checking testbench for the running ECDF distance block.
module running_ecdf_distance_top_test;
  import red_pkg::*;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned IdleWait   = 1300;
  // Grid entries that are loaded up front; samples never walk past them.
  localparam int unsigned TableSize  = 64;

  typedef struct {
    logic [1:0]  chain;
    logic [31:0] distance;
  } dist_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [8:0]  cfg_data_i = '0;

  running_ecdf_distance_top DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Shadow copy of the block's state and registers.
  logic [63:0] grid_mem [GridPoints];
  logic [16:0] target_mem [GridPoints];
  logic [23:0] hit_mem [Chains][GridPoints];
  logic [23:0] seen_mem [Chains];
  logic [2:0]  dims_reg;
  logic [8:0]  grid_reg;

  dist_t       pending_dist_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  bit          steady = 0;
  bit          hold_req = 0;
  int unsigned n_samples = 0, n_loads = 0, n_clears = 0, n_cfg = 0, n_results = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: stall pattern of its own, plus one long hold-off on request.
  int unsigned hold_left = 0, mode_left = 0, rx_mode = 0;
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = 3000;
    end
    if (mode_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(50, 400);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_mode == 0) begin
      m_axis_tready <= 1'b1;
    end else if (rx_mode == 1) begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end else begin
      m_axis_tready <= $urandom_range(0, 1);
    end
  end

  // Outputs are stable at the falling edge before the accepting rising edge.
  always @(negedge clk_i) begin
    dist_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (pending_dist_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", m_axis_tdata);
      end else begin
        want = pending_dist_q.pop_front();
        if (m_axis_tdata[1:0] !== want.chain || m_axis_tdata[33:2] !== want.distance ||
            m_axis_tdata[39:34] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected chain %0d distance %h, got chain %0d distance %h",
                     want.chain, want.distance, m_axis_tdata[1:0], m_axis_tdata[33:2]);
        end
      end
    end
  end

  function automatic logic [23:0] sat_inc(logic [23:0] v);
    return (v == CountMax) ? v : v + 1'b1;
  endfunction

  // Updates the shadow state for one accepted word and queues the distance it causes.
  function automatic void apply_word(logic [95:0] w);
    logic [1:0]  cmd, ch;
    logic [7:0]  idx;
    logic [63:0] crd;
    logic [16:0] tgt;
    int unsigned dims, g;
    longint unsigned total, e, sum, mean;
    longint signed d;
    bit hit;
    dist_t r;
    cmd = w[1:0]; ch = w[3:2]; idx = w[11:4]; crd = w[75:12]; tgt = w[92:76];
    case (cmd)
      CMD_LOAD_GRID: begin
        grid_mem[idx] = crd;
        n_loads++;
      end
      CMD_LOAD_TARGET: begin
        target_mem[idx] = (tgt > OneQ16) ? OneQ16 : tgt;
        n_loads++;
      end
      CMD_CLEAR: begin
        for (int c = 0; c < Chains; c++) begin
          seen_mem[c] = '0;
          for (int i = 0; i < GridPoints; i++) hit_mem[c][i] = '0;
        end
        n_clears++;
      end
      default: begin
        dims = (dims_reg == 0) ? 1 : (dims_reg > MaxDim) ? MaxDim : dims_reg;
        g = (grid_reg == 0) ? 1 : (grid_reg > GridPoints) ? GridPoints : grid_reg;
        seen_mem[ch] = sat_inc(seen_mem[ch]);
        total = seen_mem[ch];
        sum = 0;
        for (int i = 0; i < g; i++) begin
          hit = 1;
          for (int k = 0; k < dims; k++)
            if ($signed(crd[16*k +: 16]) > $signed(grid_mem[i][16*k +: 16])) hit = 0;
          if (hit) hit_mem[ch][i] = sat_inc(hit_mem[ch][i]);
          e = (longint'(hit_mem[ch][i]) * 65536 + total / 2) / total;
          d = longint'(e) - longint'(target_mem[i]);
          sum += longint'(d * d);
        end
        mean = (sum + g / 2) / g;
        r.chain = ch;
        r.distance = (mean > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mean[31:0];
        pending_dist_q.push_back(r);
        n_samples++;
      end
    endcase
  endfunction

  task automatic send_word(cmd_e cmd, logic [1:0] ch, logic [7:0] idx,
                           logic [63:0] crd, logic [16:0] tgt);
    int unsigned gap;
    bit acc;
    logic [95:0] w;
    w = {3'b000, tgt, crd, idx, ch, cmd};
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    do begin
      @(negedge clk_i);
      acc = s_axis_tready;
      @(posedge clk_i);
    end while (!acc);
    apply_word(w);
  endtask

  // Stops offering words and waits until the block has nothing left to do.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    wait (pending_dist_q.size() == 0);
    repeat (IdleWait) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [8:0] val);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_DIMS) dims_reg = val[2:0];
    else grid_reg = val;
    n_cfg++;
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'h8000;
      2: return 16'h7FFF;
      default: return 16'($urandom_range(0, 16)) - 16'd8;
    endcase
  endfunction

  function automatic logic [63:0] rand_point();
    return {rand_coord(), rand_coord(), rand_coord(), rand_coord()};
  endfunction

  function automatic logic [16:0] rand_target();
    case ($urandom_range(0, 5))
      0: return 17'($urandom_range(0, 131071));
      1: return OneQ16;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // Every grid and target entry that a sample may walk is written first.
  task automatic test_load_tables();
    for (int i = 0; i < TableSize; i++) begin
      send_word(CMD_LOAD_GRID, 2'($urandom_range(0, 3)), 8'(i), rand_point(),
                17'($urandom_range(0, 131071)));
      send_word(CMD_LOAD_TARGET, 2'($urandom_range(0, 3)), 8'(i), rand_point(),
                rand_target());
    end
  endtask

  task automatic test_directed();
    send_word(CMD_LOAD_GRID, 2'd0, 8'd0, {4{16'h8000}}, '0);
    send_word(CMD_LOAD_TARGET, 2'd0, 8'd0, '0, OneQ16);
    send_word(CMD_LOAD_GRID, 2'd0, 8'd1, {4{16'h7FFF}}, '0);
    // A target above one is held at one.
    send_word(CMD_LOAD_TARGET, 2'd0, 8'd1, '1, 17'h1FFFF);
    send_word(CMD_LOAD_GRID, 2'd0, 8'd255, 64'h0, '0);
    send_word(CMD_LOAD_TARGET, 2'd0, 8'd255, '0, '0);
    // One grid point, a miss against a target of one: the mean saturates.
    write_reg(REG_GRID, 9'd1);
    send_word(CMD_SAMPLE, 2'd0, 8'd0, {4{16'h7FFF}}, '0);
    send_word(CMD_SAMPLE, 2'd1, 8'd0, {4{16'h8000}}, '0);
    write_reg(REG_GRID, 9'd0);
    write_reg(REG_DIMS, 9'd0);
    send_word(CMD_SAMPLE, 2'd2, 8'hFF, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000}, 17'h1FFFF);
    write_reg(REG_DIMS, 9'd7);
    write_reg(REG_GRID, 9'(TableSize));
    for (int c = 0; c < Chains; c++) send_word(CMD_SAMPLE, 2'(c), 8'd0, {4{16'h8000}}, '0);
    send_word(CMD_SAMPLE, 2'd3, 8'd0, {16'h7FFF, 48'h0}, '0);
    send_word(CMD_CLEAR, 2'd0, 8'd0, '0, '0);
    send_word(CMD_SAMPLE, 2'd3, 8'd0, 64'h0, '0);
    write_reg(REG_DIMS, 9'd4);
    write_reg(REG_GRID, 9'd3);
    send_word(CMD_SAMPLE, 2'd0, 8'd0, {16'h8000, 16'h7FFF, 16'h0, 16'h8000}, '0);
    send_word(CMD_SAMPLE, 2'd0, 8'd0, 64'h0, '0);
    write_reg(REG_GRID, 9'(TableSize));
    send_word(CMD_SAMPLE, 2'd1, 8'd0, rand_point(), '0);
  endtask

  // Mostly samples over small grids, with loads, clears and register changes mixed in.
  task automatic test_random(int unsigned count);
    int unsigned r;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
        write_reg(REG_DIMS, 9'($urandom_range(0, 7)));
        r = $urandom_range(0, 9);
        write_reg(REG_GRID, (r == 0) ? 9'd0 :
                            (r == 1) ? 9'(TableSize) : 9'($urandom_range(1, 24)));
      end
      r = $urandom_range(0, 99);
      if (r < 65)
        send_word(CMD_SAMPLE, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  rand_point(), 17'($urandom_range(0, 131071)));
      else if (r < 80)
        send_word(CMD_LOAD_GRID, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  rand_point(), 17'($urandom_range(0, 131071)));
      else if (r < 95)
        send_word(CMD_LOAD_TARGET, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  rand_point(), rand_target());
      else
        send_word(CMD_CLEAR, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  rand_point(), 17'($urandom_range(0, 131071)));
    end
    steady = 0;
  endtask

  // The receiver holds off while samples keep coming, so the input stalls.
  task automatic test_backpressure();
    write_reg(REG_GRID, 9'd8);
    hold_req = 1;
    steady = 1;
    for (int n = 0; n < 12; n++)
      send_word(CMD_SAMPLE, 2'($urandom_range(0, 3)), 8'd0, rand_point(), 17'd0);
    steady = 0;
  endtask

  // The sender pauses until every distance has come back, then resumes.
  task automatic test_drain_pause();
    for (int n = 0; n < 6; n++)
      send_word(CMD_SAMPLE, 2'($urandom_range(0, 3)), 8'd0, rand_point(), 17'd0);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    wait (pending_dist_q.size() == 0);
    @(posedge clk_i);
    for (int n = 0; n < 6; n++)
      send_word(CMD_SAMPLE, 2'($urandom_range(0, 3)), 8'd0, rand_point(), 17'd0);
  endtask

  initial begin
    dims_reg = 3'd1;
    grid_reg = 9'd256;
    for (int c = 0; c < Chains; c++) begin
      seen_mem[c] = '0;
      for (int i = 0; i < GridPoints; i++) hit_mem[c][i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_tables();
    test_directed();
    test_backpressure();
    test_drain_pause();
    test_random(230);
    wait_idle();
    $display("covered %0d samples, %0d loads, %0d clears, %0d register writes",
             n_samples, n_loads, n_clears, n_cfg);
    $display("checked %0d distances, %0d mismatches, %0d left waiting",
             n_results, mismatches, pending_dist_q.size());
    if (mismatches == 0 && pending_dist_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
